### src/antialiased_line_rasterizer_unit_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the anti-aliased line rasterizer
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_UNIT_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_UNIT_MACROS_SVH

// checked on every rising clock edge outside of reset
`define AALR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define AALR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/aalr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aalr_pkg
// shared types and codes of the anti-aliased line rasterizer
// ----------------------------------------------------------------------------
package aalr_pkg;

   // operation codes of a request transaction
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ORDER = 8'b0000_0010,
      ST_DELTA = 8'b0000_0100,
      ST_LOAD  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_SIGN  = 8'b0010_0000,
      ST_EP1   = 8'b0100_0000,
      ST_EP2   = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

### src/aalr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aalr channel interfaces
// valid/ready channels for line requests and pixel pair responses
// ----------------------------------------------------------------------------

// request channel: start a line or step to the next interior pair
interface aalr_req_if #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, operation, start_x, start_y, end_x, end_y,
                   input  ready);
   modport sink   (input  valid, operation, start_x, start_y, end_x, end_y,
                   output ready);
endinterface

// response channel: one pixel pair per transaction
interface aalr_rsp_if #(parameter int COORD_BITS = 12, parameter int LEVEL_BITS = 3);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         pair_on_x;
   logic [LEVEL_BITS-1:0]        level_first;
   logic [LEVEL_BITS-1:0]        level_second;
   logic                         last_of_line;

   modport source (output valid, pixel_x, pixel_y, pair_on_x, level_first,
                          level_second, last_of_line,
                   input  ready);
   modport sink   (input  valid, pixel_x, pixel_y, pair_on_x, level_first,
                          level_second, last_of_line,
                   output ready);
endinterface
`default_nettype wire

### src/antialiased_line_rasterizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit
// Wu-style anti-aliased line stepper in fixed point with a serial divider
// ----------------------------------------------------------------------------
//  channel | dir | port | transaction
//  --------+-----+------+------------------------------------------------
//  request | in  | req  | start a line (endpoints) or step one pair
//  result  | out | rsp  | one pixel pair; two per start, one per active step
//
//  step: a new step is taken whenever the result register is free or drains
//  start: the sequencer orders the endpoints, takes the deltas, loads the
//    restoring divider (one gradient bit per cycle over FRAC_BITS + 1 steps),
//    signs the gradient, registers each endpoint pair once the result slot
//    is free and returns to idle; a zero-length line skips the divider
//  reset: synchronous, active high; clears sequencer, line flag, result valid
//  rsp stalls hold the result register and block new requests
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16,
   parameter int LEVEL_BITS = 3
) (
   input  wire logic   clock,
   input  wire logic   reset,
   aalr_req_if.sink    req,
   aalr_rsp_if.source  rsp
);

   localparam int CW        = COORD_BITS;
   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int GRAD_BITS = FRAC_BITS + 2;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int NUM_BITS  = COORD_BITS + FRAC_BITS + 2;
   localparam int CNT_BITS  = $clog2(QUO_BITS);

   // fixed endpoint intensity
   localparam logic [63:0] LVL_FULL = (64'd1 << FRAC_BITS) - 64'd1;
   localparam logic [63:0] LVL_HALF = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] LVL_GAP  = LVL_FULL - LVL_HALF;
   localparam logic [63:0] LVL_PROD = ((LVL_FULL * LVL_GAP) + LVL_HALF) >> FRAC_BITS;
   localparam logic [63:0] LVL_END  = LVL_PROD >> (FRAC_BITS - LEVEL_BITS);
   localparam logic [LEVEL_BITS-1:0] ENDPOINT_LEVEL = LVL_END[LEVEL_BITS-1:0];

   localparam logic [CW-1:0]       COORD_ONE = CW'(1);
   localparam logic [CNT_BITS-1:0] CNT_START = CNT_BITS'(QUO_BITS - 1);

   // sequencer and line state
   aalr_pkg::state_type state_ff, state_in;
   logic                 line_active_ff, line_active_in;
   logic                 steep_ff, steep_in;
   logic [CW-1:0]        major_position_ff, major_position_in;
   logic [CW-1:0]        major_stop_ff, major_stop_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [GRAD_BITS-1:0] grad_ff, grad_in;

   // endpoint registers, ordered in place after the order step
   logic signed [CW-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [CW-1:0] x2_ff, x2_in, y2_ff, y2_in;

   // divider operands and state
   logic [CW-1:0]        majd_ff, majd_in;
   logic [CW-1:0]        am_ff, am_in;
   logic                 mneg_ff, mneg_in;
   logic [CW:0]          rem_ff, rem_in;
   logic [QUO_BITS-1:0]  low_ff, low_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         px_ff, px_in, py_ff, py_in;
   logic                  onx_ff, onx_in;
   logic [LEVEL_BITS-1:0] lv1_ff, lv1_in, lv2_ff, lv2_in;
   logic                  last_ff, last_in;

   logic slot_free;
   logic req_take;
   logic out_load;

   // ordering terms
   logic signed [CW:0] dx_w, dy_w;
   logic [CW:0]        adx_w, ady_w;
   logic               steep_w, swap_w;

   // delta terms
   logic [CW-1:0]      maj1_w, maj2_w, min1_w, min2_w;
   logic [CW:0]        majd_full_w;
   logic signed [CW:0] mind_full_w;
   logic [CW:0]        am_full_w;

   // divider terms
   logic [NUM_BITS-1:0] num_w;
   logic [CW+1:0]       trial_w, divisor_w, diff_w;
   logic                ge_w;

   // step terms
   logic [CW:0]           pos_next_w;
   logic                  step_last_w;
   logic [CW-1:0]         minor_int_w;
   logic [LEVEL_BITS-1:0] frac_lvl_w;
   logic [GRAD_BITS-1:0]  quo_ext_w;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == aalr_pkg::ST_IDLE) && slot_free;
   assign req_take  = req.valid && req.ready;

   // major axis and endpoint order
   assign dx_w    = $signed({x2_ff[CW-1], x2_ff}) - $signed({x1_ff[CW-1], x1_ff});
   assign dy_w    = $signed({y2_ff[CW-1], y2_ff}) - $signed({y1_ff[CW-1], y1_ff});
   assign adx_w   = dx_w[CW] ? (~dx_w + 1'b1) : dx_w;
   assign ady_w   = dy_w[CW] ? (~dy_w + 1'b1) : dy_w;
   assign steep_w = !(adx_w > ady_w);
   assign swap_w  = steep_w ? (y1_ff > y2_ff) : (x1_ff > x2_ff);

   // major and minor coordinates of the ordered endpoints
   assign maj1_w = steep_ff ? y1_ff : x1_ff;
   assign maj2_w = steep_ff ? y2_ff : x2_ff;
   assign min1_w = steep_ff ? x1_ff : y1_ff;
   assign min2_w = steep_ff ? x2_ff : y2_ff;
   assign majd_full_w = {maj2_w[CW-1], maj2_w} - {maj1_w[CW-1], maj1_w};
   assign mind_full_w = $signed({min2_w[CW-1], min2_w}) - $signed({min1_w[CW-1], min1_w});
   assign am_full_w   = mind_full_w[CW] ? (~mind_full_w + 1'b1) : mind_full_w;

   // rounded quotient: (am * 2^(F+1) + majd) / (2 * majd)
   assign num_w     = {1'b0, am_ff, {QUO_BITS{1'b0}}} + {{(NUM_BITS-CW){1'b0}}, majd_ff};
   assign trial_w   = {rem_ff, low_ff[QUO_BITS-1]};
   assign divisor_w = {1'b0, majd_ff, 1'b0};
   assign diff_w    = trial_w - divisor_w;
   assign ge_w      = trial_w >= divisor_w;
   assign quo_ext_w = {1'b0, quo_ff};

   // interior pair from the accumulator
   assign pos_next_w  = {major_position_ff[CW-1], major_position_ff} + {{CW{1'b0}}, 1'b1};
   assign step_last_w = $signed(pos_next_w) >= $signed({major_stop_ff[CW-1], major_stop_ff});
   assign minor_int_w = acc_ff[FRAC_BITS+CW-1:FRAC_BITS];
   assign frac_lvl_w  = acc_ff[FRAC_BITS-1 -: LEVEL_BITS];

   // sequencer and datapath next state
   always_comb begin
      state_in          = state_ff;
      line_active_in    = line_active_ff;
      steep_in          = steep_ff;
      major_position_in = major_position_ff;
      major_stop_in     = major_stop_ff;
      acc_in            = acc_ff;
      grad_in           = grad_ff;
      x1_in             = x1_ff;
      y1_in             = y1_ff;
      x2_in             = x2_ff;
      y2_in             = y2_ff;
      majd_in           = majd_ff;
      am_in             = am_ff;
      mneg_in           = mneg_ff;
      rem_in            = rem_ff;
      low_in            = low_ff;
      quo_in            = quo_ff;
      cnt_in            = cnt_ff;
      out_load          = 1'b0;
      px_in             = px_ff;
      py_in             = py_ff;
      onx_in            = onx_ff;
      lv1_in            = lv1_ff;
      lv2_in            = lv2_ff;
      last_in           = last_ff;

      unique case (state_ff)
         aalr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req.operation == aalr_pkg::OP_START) begin
                  x1_in    = req.start_x;
                  y1_in    = req.start_y;
                  x2_in    = req.end_x;
                  y2_in    = req.end_y;
                  state_in = aalr_pkg::ST_ORDER;
               end else if (line_active_ff) begin
                  out_load          = 1'b1;
                  onx_in            = steep_ff;
                  px_in             = steep_ff ? minor_int_w : major_position_ff;
                  py_in             = steep_ff ? major_position_ff : minor_int_w;
                  lv1_in            = ~frac_lvl_w;
                  lv2_in            = frac_lvl_w;
                  last_in           = step_last_w;
                  major_position_in = pos_next_w[CW-1:0];
                  acc_in            = acc_ff + {{(ACC_BITS-GRAD_BITS){grad_ff[GRAD_BITS-1]}},
                                                grad_ff};
                  line_active_in    = !step_last_w;
               end
            end
         end
         aalr_pkg::ST_ORDER: begin
            steep_in = steep_w;
            if (swap_w) begin
               x1_in = x2_ff;
               y1_in = y2_ff;
               x2_in = x1_ff;
               y2_in = y1_ff;
            end
            state_in = aalr_pkg::ST_DELTA;
         end
         aalr_pkg::ST_DELTA: begin
            majd_in  = majd_full_w[CW-1:0];
            mneg_in  = mind_full_w[CW];
            am_in    = am_full_w[CW-1:0];
            state_in = aalr_pkg::ST_LOAD;
         end
         aalr_pkg::ST_LOAD: begin
            rem_in   = num_w[NUM_BITS-1:QUO_BITS];
            low_in   = num_w[QUO_BITS-1:0];
            quo_in   = '0;
            cnt_in   = CNT_START;
            // zero-length line keeps a zero gradient
            state_in = (majd_ff == '0) ? aalr_pkg::ST_SIGN : aalr_pkg::ST_DIV;
         end
         aalr_pkg::ST_DIV: begin
            // one restoring division step per cycle
            rem_in = ge_w ? diff_w[CW:0] : trial_w[CW:0];
            low_in = {low_ff[QUO_BITS-2:0], 1'b0};
            quo_in = {quo_ff[QUO_BITS-2:0], ge_w};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = aalr_pkg::ST_SIGN;
            end
         end
         aalr_pkg::ST_SIGN: begin
            grad_in           = mneg_ff ? ({GRAD_BITS{1'b0}} - quo_ext_w) : quo_ext_w;
            major_position_in = maj1_w + COORD_ONE;
            major_stop_in     = maj2_w;
            line_active_in    = (majd_ff[CW-1:1] != '0);
            state_in          = aalr_pkg::ST_EP1;
         end
         aalr_pkg::ST_EP1: begin
            // accumulator starts one step in from endpoint one
            acc_in = {min1_w[CW-1], min1_w, {FRAC_BITS{1'b0}}}
                   + {{(ACC_BITS-GRAD_BITS){grad_ff[GRAD_BITS-1]}}, grad_ff};
            if (slot_free) begin
               out_load = 1'b1;
               px_in    = x1_ff;
               py_in    = y1_ff;
               onx_in   = steep_ff;
               lv1_in   = ENDPOINT_LEVEL;
               lv2_in   = '0;
               last_in  = 1'b0;
               state_in = aalr_pkg::ST_EP2;
            end
         end
         aalr_pkg::ST_EP2: begin
            if (slot_free) begin
               out_load = 1'b1;
               px_in    = x2_ff;
               py_in    = y2_ff;
               onx_in   = steep_ff;
               lv1_in   = ENDPOINT_LEVEL;
               lv2_in   = '0;
               last_in  = !line_active_ff;
               state_in = aalr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aalr_pkg::ST_IDLE;
         end
      endcase
   end

   // result register valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= aalr_pkg::ST_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      steep_ff          <= steep_in;
      major_position_ff <= major_position_in;
      major_stop_ff     <= major_stop_in;
      acc_ff            <= acc_in;
      grad_ff           <= grad_in;
      x1_ff             <= x1_in;
      y1_ff             <= y1_in;
      x2_ff             <= x2_in;
      y2_ff             <= y2_in;
      majd_ff           <= majd_in;
      am_ff             <= am_in;
      mneg_ff           <= mneg_in;
      rem_ff            <= rem_in;
      low_ff            <= low_in;
      quo_ff            <= quo_in;
      cnt_ff            <= cnt_in;
      px_ff             <= px_in;
      py_ff             <= py_in;
      onx_ff            <= onx_in;
      lv1_ff            <= lv1_in;
      lv2_ff            <= lv2_in;
      last_ff           <= last_in;
   end

   // result channel
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_x      = px_ff;
   assign rsp.pixel_y      = py_ff;
   assign rsp.pair_on_x    = onx_ff;
   assign rsp.level_first  = lv1_ff;
   assign rsp.level_second = lv2_ff;
   assign rsp.last_of_line = last_ff;

endmodule
`default_nettype wire

### src/aalr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aalr_checker
// port-level checks of the anti-aliased line rasterizer, bound to the top
// ----------------------------------------------------------------------------
`include "antialiased_line_rasterizer_unit_macros.svh"

module aalr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_operation,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // a stalled result stays offered
   `AALR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // no new request while a result waits on a stalled consumer
   `AALR_ASSERT(a_no_take_on_stall, rsp_valid && !rsp_ready |-> !req_ready, "request taken while result stalled")

   // a start transaction blocks requests and empties the result slot
   `AALR_ASSERT(a_start_busy, req_valid && req_ready && req_operation == aalr_pkg::OP_START |=> !req_ready && !rsp_valid, "start did not enter setup")

   // reset leaves no result behind
   `AALR_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind antialiased_line_rasterizer_unit aalr_checker u_aalr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_operation (req.operation),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready)
);
`default_nettype wire
